[rtl/core/six_step_bemf_commutator_top_macros.svh]
// assertion macros for the six-step commutator
`ifndef SIX_STEP_BEMF_COMMUTATOR_TOP_MACROS_SVH
`define SIX_STEP_BEMF_COMMUTATOR_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define SSBC_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("ssbc assertion failed");
`define SSBC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ssbc assertion failed");
`else
`define SSBC_ASSERT(label, prop)
`define SSBC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

[rtl/core/ssbc_pkg.sv]
package ssbc_pkg;

	typedef logic [2:0] step_t;
	typedef logic [1:0] drive_t;

	localparam step_t STEP_FIRST = 3'd1;
	localparam step_t STEP_LAST  = 3'd6;

	localparam drive_t DRIVE_FLOAT = 2'd0;
	localparam drive_t DRIVE_HIGH  = 2'd1;
	localparam drive_t DRIVE_LOW   = 2'd2;

	localparam int PAYLOAD_W = 16;
	localparam logic [PAYLOAD_W-1:0] THRESHOLD_RESET = 16'd3000;

	typedef logic [1:0] reg_index_t;
	localparam reg_index_t REG_LOW_SPEED_THRESHOLD = 2'd0;
	localparam reg_index_t REG_RISING_MODE         = 2'd1;

	typedef struct packed {
		drive_t a;
		drive_t b;
		drive_t c;
	} drive_pattern_t;

	typedef struct packed {
		step_t          step;
		logic           wrapped;
		drive_pattern_t drive;
	} step_res_t;

	function automatic drive_pattern_t drive_for_step(input step_t step);
		drive_pattern_t p;
		case (step)
			3'd1:    p = '{a: DRIVE_HIGH,  b: DRIVE_LOW,   c: DRIVE_FLOAT};
			3'd2:    p = '{a: DRIVE_HIGH,  b: DRIVE_FLOAT, c: DRIVE_LOW};
			3'd3:    p = '{a: DRIVE_FLOAT, b: DRIVE_HIGH,  c: DRIVE_LOW};
			3'd4:    p = '{a: DRIVE_LOW,   b: DRIVE_HIGH,  c: DRIVE_FLOAT};
			3'd5:    p = '{a: DRIVE_LOW,   b: DRIVE_FLOAT, c: DRIVE_HIGH};
			3'd6:    p = '{a: DRIVE_FLOAT, b: DRIVE_LOW,   c: DRIVE_HIGH};
			default: p = '{a: DRIVE_FLOAT, b: DRIVE_FLOAT, c: DRIVE_FLOAT};
		endcase
		return p;
	endfunction

endpackage

[rtl/core/ssbc_step_logic.sv]
module ssbc_step_logic
	import ssbc_pkg::*;
(
	input  step_t                  step,
	input  logic [2:0]             comparators,
	input  logic [PAYLOAD_W-1:0]   rate,
	input  logic [PAYLOAD_W-1:0]   threshold,
	input  logic                   rising,
	output step_res_t              res
);

	logic  sense;
	logic  advance;
	step_t step_inc;

	always_comb begin
		case (step) inside
			3'd1, 3'd6: sense = comparators[2];
			3'd2, 3'd3: sense = comparators[1];
			default:    sense = comparators[0];
		endcase
	end

	// at low speed a low comparator alone moves the step on
	assign advance = ((rate < threshold) && !sense) || (rising ? sense : !sense);

	always_comb begin
		step_inc    = advance ? step + 3'd1 : step;
		res.wrapped = 1'b0;
		res.step    = step_inc;
		if ((step_inc == 3'd0) || (step_inc > STEP_LAST)) begin
			res.step    = STEP_FIRST;
			res.wrapped = 1'b1;
		end
		res.drive = drive_for_step(res.step);
	end

endmodule

[rtl/core/six_step_bemf_commutator_top.sv]
// six-step sensorless commutator
// input channel (in_valid/in_ready): one transaction per commutation tick with the
// three back-emf comparator bits, the commutation rate and the timer count.
// output channel (out_valid/out_ready): one result transaction per input, carrying
// the step, the three phase drives, drive_update, electrical_period, period_update.
// configuration channel (cfg_valid/cfg_ready): cfg_index 0 is the low-speed
// threshold, 1 is rising mode; other indexes are ignored. cfg_ready is always high.
// path: an accepted input is held in the input register, then moves into the
// result register, from which it is presented as the output transaction.
// throughput: one item per cycle while out_ready is high; the step and wrap
// state update as an item moves from the input register into the result register.
// reset: step 1, no applied step (the first result has drive_update set),
// period and wrap time zero, threshold 3000, rising mode on.
// stall: while out_ready is low the result holds and one more input can be taken
// into the input register; in_ready then drops until the result is taken.
`include "six_step_bemf_commutator_top_macros.svh"

module six_step_bemf_commutator_top
	import ssbc_pkg::*;
#(
	parameter int TIMER_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 comparator_0,
	input  logic                 comparator_1,
	input  logic                 comparator_2,
	input  logic [15:0]          commutation_rate,
	input  logic [15:0]          timer_now,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [2:0]           step_now,
	output logic [1:0]           phase_a_drive,
	output logic [1:0]           phase_b_drive,
	output logic [1:0]           phase_c_drive,
	output logic                 drive_update,
	output logic [15:0]          electrical_period,
	output logic                 period_update,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [1:0]           cfg_index,
	input  logic [15:0]          cfg_data
);

	// timer bits that survive both the timer mask and the 16-bit field
	localparam int CntW = (TIMER_BITS < PAYLOAD_W) ? TIMER_BITS : PAYLOAD_W;

	logic [PAYLOAD_W-1:0] threshold_q;
	logic                 rising_q;

	logic                 valid_s1;
	logic [2:0]           comp_s1;
	logic [PAYLOAD_W-1:0] rate_s1;
	logic [PAYLOAD_W-1:0] timer_s1;
	logic                 move_s1;

	step_t                step_q;
	step_t                applied_q;
	logic [CntW-1:0]      last_wrap_q;
	logic [CntW-1:0]      period_diff;
	step_res_t            res;

	logic                 out_valid_q;
	step_t                step_now_q;
	drive_pattern_t       drive_q;
	logic                 drive_update_q;
	logic [PAYLOAD_W-1:0] last_period_q;
	logic                 period_update_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RESET;
			rising_q    <= 1'b1;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_LOW_SPEED_THRESHOLD: threshold_q <= cfg_data;
				REG_RISING_MODE:         rising_q    <= cfg_data[0];
				default:                 ;
			endcase
		end
	end

	assign move_s1  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || move_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			comp_s1  <= {comparator_2, comparator_1, comparator_0};
			rate_s1  <= commutation_rate;
			timer_s1 <= timer_now;
		end
	end

	ssbc_step_logic u_step (
		.step        (step_q),
		.comparators (comp_s1),
		.rate        (rate_s1),
		.threshold   (threshold_q),
		.rising      (rising_q),
		.res         (res)
	);

	assign period_diff = timer_s1[CntW-1:0] - last_wrap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q        <= STEP_FIRST;
			applied_q     <= '0;
			last_wrap_q   <= '0;
			last_period_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (move_s1) begin
				out_valid_q <= 1'b1;
				step_q      <= res.step;
				applied_q   <= res.step;
				if (res.wrapped) begin
					last_wrap_q   <= timer_s1[CntW-1:0];
					last_period_q <= PAYLOAD_W'(period_diff);
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			step_now_q      <= res.step;
			drive_q         <= res.drive;
			drive_update_q  <= (applied_q != res.step);
			period_update_q <= res.wrapped;
		end
	end

	assign out_valid         = out_valid_q;
	assign step_now          = step_now_q;
	assign phase_a_drive     = drive_q.a;
	assign phase_b_drive     = drive_q.b;
	assign phase_c_drive     = drive_q.c;
	assign drive_update      = drive_update_q;
	assign electrical_period = last_period_q;
	assign period_update     = period_update_q;

	`SSBC_ASSERT(a_step_in_range, (step_q >= STEP_FIRST) && (step_q <= STEP_LAST))
	`SSBC_ASSERT(a_applied_tracks_step, (applied_q == 3'd0) || (applied_q == step_q))
	`SSBC_ASSERT(a_wrap_lands_on_first, !(out_valid_q && period_update_q) || (step_now_q == STEP_FIRST))
	`SSBC_ASSERT_NEXT(a_move_fills_output, move_s1, out_valid_q)

endmodule
